// ----- rtl/core/rbd_pkg.sv -----
// shared types and constants for the ring buffer deque
package rbd_pkg;

  localparam int DataW  = 32;
  localparam int CountW = 11;

  localparam logic [DataW-1:0] NoData = {DataW{1'b1}};

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_STATUS     = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // what the back end must do with one word, plus the result fields known up front
  typedef struct packed {
    logic              wr;
    logic              rd;
    status_e           status;
    logic [CountW-1:0] count;
    logic              is_empty;
  } op_info_t;

endpackage

// ----- rtl/core/rbd_front.sv -----
// front end: decodes commands and owns the head, tail and count registers
module rbd_front #(
  parameter int DEPTH = 1024,
  parameter int AddrW = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [2:0]           cmd_i,
  output rbd_pkg::op_info_t    info_o,
  output logic [AddrW-1:0]     addr_o
);
  import rbd_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [AddrW-1:0] Half = AddrW'(DEPTH / 2);
  localparam logic [AddrW-1:0] Last = AddrW'(DEPTH - 1);
  localparam logic [CntW-1:0]  Full = CntW'(DEPTH);

  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             at_front;
  logic             wr, rd;
  status_e          st;
  logic [AddrW-1:0] addr;

  function automatic logic [AddrW-1:0] idx_next(input logic [AddrW-1:0] i);
    return (i == Last) ? '0 : i + AddrW'(1);
  endfunction

  function automatic logic [AddrW-1:0] idx_prev(input logic [AddrW-1:0] i);
    return (i == '0) ? Last : i - AddrW'(1);
  endfunction

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    addr     = head_q;
    wr       = 1'b0;
    rd       = 1'b0;
    st       = ST_OK;
    at_front = (cmd_i == CMD_POP_FRONT) || (cmd_i == CMD_PEEK_FRONT);
    unique case (cmd_i)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (cnt_q == Full) begin
          st = ST_FULL;
        end else begin
          wr    = 1'b1;
          cnt_d = cnt_q + CntW'(1);
          if (cnt_q == '0) begin
            // first word always lands in the middle
            head_d = Half;
            tail_d = Half;
            addr   = Half;
          end else if (cmd_i == CMD_PUSH_FRONT) begin
            head_d = idx_prev(head_q);
            addr   = head_d;
          end else begin
            tail_d = idx_next(tail_q);
            addr   = tail_d;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        if (cnt_q == '0) begin
          st = ST_EMPTY;
        end else begin
          rd   = 1'b1;
          addr = at_front ? head_q : tail_q;
          if ((cmd_i == CMD_POP_FRONT) || (cmd_i == CMD_POP_BACK)) begin
            cnt_d = cnt_q - CntW'(1);
            if (cnt_q == CntW'(1)) begin
              head_d = Half;
              tail_d = Half;
            end else if (at_front) begin
              head_d = idx_next(head_q);
            end else begin
              tail_d = idx_prev(tail_q);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= Half;
      tail_q <= Half;
      cnt_q  <= '0;
    end else if (accept_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  assign info_o.wr       = wr;
  assign info_o.rd       = rd;
  assign info_o.status   = st;
  assign info_o.count    = CountW'(cnt_d);
  assign info_o.is_empty = (cnt_d == '0);
  assign addr_o          = addr;

endmodule

// ----- rtl/core/rbd_fifo.sv -----
// two-entry queue between the front and back ends
module rbd_fifo #(
  parameter int AddrW = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_valid_i,
  output logic                       push_ready_o,
  input  rbd_pkg::op_info_t          info_i,
  input  logic [AddrW-1:0]           addr_i,
  input  logic [rbd_pkg::DataW-1:0]  value_i,
  output logic                       pop_valid_o,
  input  logic                       pop_ready_i,
  output rbd_pkg::op_info_t          info_o,
  output logic [AddrW-1:0]           addr_o,
  output logic [rbd_pkg::DataW-1:0]  value_o
);
  import rbd_pkg::*;

  op_info_t         info_q  [2];
  logic [AddrW-1:0] addr_q  [2];
  logic [DataW-1:0] value_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;
  logic             push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      info_q[wr_ptr_q]  <= info_i;
      addr_q[wr_ptr_q]  <= addr_i;
      value_q[wr_ptr_q] <= value_i;
    end
  end

  assign info_o  = info_q[rd_ptr_q];
  assign addr_o  = addr_q[rd_ptr_q];
  assign value_o = value_q[rd_ptr_q];

endmodule

// ----- rtl/core/rbd_back.sv -----
// back end: word store access and the output register
module rbd_back #(
  parameter int DEPTH = 1024,
  parameter int AddrW = $clog2(DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  rbd_pkg::op_info_t                 info_i,
  input  logic [AddrW-1:0]                  addr_i,
  input  logic [rbd_pkg::DataW-1:0]         value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rbd_pkg::DataW-1:0]  data_o,
  output logic [1:0]                        status_o,
  output logic [rbd_pkg::CountW-1:0]        count_o,
  output logic                              is_empty_o
);
  import rbd_pkg::*;

  logic [DataW-1:0] mem [DEPTH];
  logic [DataW-1:0] rdata_q;
  op_info_t         info_q;
  logic             valid_q;
  logic             take;

  // take the next word whenever the output register is free or drains
  assign take        = pop_valid_i && (!valid_q || out_ready_i);
  assign pop_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (take && info_i.wr) mem[addr_i] <= value_i;
    if (take && info_i.rd) rdata_q <= mem[addr_i];
    if (take)              info_q  <= info_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = info_q.rd ? $signed(rdata_q) : $signed(NoData);
  assign status_o    = info_q.status;
  assign count_o     = info_q.count;
  assign is_empty_o  = info_q.is_empty;

endmodule

// ----- rtl/core/ring_buffer_deque.sv -----
// ring buffer deque: front decoder, two-entry queue and store/output back end
// a result passes through a queue entry and then the output register before it shows up on the output
// throughput: one command per cycle while the output is not held back, set by the single store port in the back end
// a pop or peek reads the store when the back end takes its command from the queue
// reset: head and tail at DEPTH/2, count zero, queue and output empty; store not cleared
module ring_buffer_deque #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        cmd_i,
  input  logic signed [rbd_pkg::DataW-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rbd_pkg::DataW-1:0]  data_o,
  output logic [1:0]                        status_o,
  output logic [rbd_pkg::CountW-1:0]        count_o,
  output logic                              is_empty_o
);
  import rbd_pkg::*;

  localparam int AddrW = $clog2(DEPTH);

  logic             accept;
  op_info_t         front_info, back_info;
  logic [AddrW-1:0] front_addr, back_addr;
  logic [DataW-1:0] back_value;
  logic             q_valid, q_ready;

  assign accept = in_valid_i && in_ready_o;

  rbd_front #(.DEPTH(DEPTH), .AddrW(AddrW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .info_o   (front_info),
    .addr_o   (front_addr)
  );

  rbd_fifo #(.AddrW(AddrW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .info_i       (front_info),
    .addr_i       (front_addr),
    .value_i      ($unsigned(value_i)),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .info_o       (back_info),
    .addr_o       (back_addr),
    .value_o      (back_value)
  );

  rbd_back #(.DEPTH(DEPTH), .AddrW(AddrW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_valid),
    .pop_ready_o (q_ready),
    .info_i      (back_info),
    .addr_i      (back_addr),
    .value_i     (back_value),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o)
  );

  // no word returned for a pop or peek on an empty deque or for a dropped push
  a_no_data_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (data_o == -32'sd1))
    else $error("data on empty or dropped push");

  // empty flag tracks the count while the count fits its field
  a_empty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (DEPTH < 2048) |-> (is_empty_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

  // a dropped push never reports an empty deque
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> !is_empty_o)
    else $error("full drop with empty deque");

endmodule

// ----- test/deque_checker.sv -----
// checker for the ring buffer deque: tracks both channels, predicts each result and compares it
`timescale 1ns / 100ps

module deque_checker #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [2:0]                   cmd_i,
  input  logic [rbd_pkg::DataW-1:0]    value_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [rbd_pkg::DataW-1:0]    data_i,
  input  logic [1:0]                   status_i,
  input  logic [rbd_pkg::CountW-1:0]   count_i,
  input  logic                         is_empty_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           level_o,
  output int                           checked_o,
  output int                           drops_o,
  output int                           empty_reads_o,
  output int                           peak_o
);
  import rbd_pkg::*;

  typedef struct packed {
    logic [DataW-1:0]  data;
    status_e           status;
    logic [CountW-1:0] count;
    logic              is_empty;
  } deque_result_t;

  logic [DataW-1:0] deque_mem [DEPTH];
  int front_idx = DEPTH / 2;
  int back_idx = DEPTH / 2;
  int level = 0;
  int fails = 0;
  int checked = 0;
  int drops = 0;
  int empty_reads = 0;
  int peak = 0;
  deque_result_t expected_q [$];

  assign fail_count_o  = fails;
  assign pending_o     = expected_q.size();
  assign level_o       = level;
  assign checked_o     = checked;
  assign drops_o       = drops;
  assign empty_reads_o = empty_reads;
  assign peak_o        = peak;

  function automatic deque_result_t apply_command(input logic [2:0] op,
                                                  input logic [DataW-1:0] word);
    deque_result_t res;
    logic at_front;
    res.data   = NoData;
    res.status = ST_OK;
    if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) begin
      if (level >= DEPTH) begin
        res.status = ST_FULL;
        drops++;
      end else begin
        // a push into an empty deque parks both ends in the middle
        if (level == 0) begin
          front_idx = DEPTH / 2;
          back_idx  = DEPTH / 2;
        end else if (op == CMD_PUSH_FRONT) begin
          front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
        end else begin
          back_idx = (back_idx == DEPTH - 1) ? 0 : back_idx + 1;
        end
        deque_mem[(op == CMD_PUSH_FRONT) ? front_idx : back_idx] = word;
        level++;
        if (level > peak) peak = level;
      end
    end else if (op >= CMD_POP_FRONT && op <= CMD_PEEK_BACK) begin
      if (level == 0) begin
        res.status = ST_EMPTY;
        empty_reads++;
      end else begin
        at_front = (op == CMD_POP_FRONT || op == CMD_PEEK_FRONT);
        res.data = deque_mem[at_front ? front_idx : back_idx];
        if (op == CMD_POP_FRONT || op == CMD_POP_BACK) begin
          level--;
          if (level == 0) begin
            front_idx = DEPTH / 2;
            back_idx  = DEPTH / 2;
          end else if (at_front) begin
            front_idx = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
          end else begin
            back_idx = (back_idx == 0) ? DEPTH - 1 : back_idx - 1;
          end
        end
      end
    end
    // status and any unused code only report occupancy
    res.count    = level[CountW-1:0];
    res.is_empty = (level == 0);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    fails++;
    if (fails <= 40) begin
      $display("%0t: result %0d: %s got %0d expected %0d", $time, checked, what,
               $signed(got), $signed(want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    deque_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      level     = 0;
      front_idx = DEPTH / 2;
      back_idx  = DEPTH / 2;
    end else begin
      // compare before predicting so a word accepted this edge cannot match early
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("word with nothing expected, data", data_i, NoData);
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (data_i !== want.data) report_mismatch("data", data_i, want.data);
          if (status_i !== want.status) begin
            report_mismatch("status", DataW'(status_i), DataW'(want.status));
          end
          if (count_i !== want.count) begin
            report_mismatch("count", DataW'(count_i), DataW'(want.count));
          end
          if (is_empty_i !== want.is_empty) begin
            report_mismatch("is_empty", DataW'(is_empty_i), DataW'(want.is_empty));
          end
        end
        checked++;
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.insert(expected_q.size(), apply_command(cmd_i, value_i));
      end
    end
  end

endmodule

// ----- test/testbench.sv -----
// top of the deque testbench: clock, reset, command stimulus, output back-pressure and verdict
`timescale 1ns / 100ps

module testbench;
  import rbd_pkg::*;

  localparam int Depth       = 1024;
  localparam int ResetCycles = 6;
  localparam int HoldStart   = 300;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 400000;
  localparam logic [2:0] CmdUnused = 3'd7;

  typedef enum logic [1:0] {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_e;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid;
  logic in_ready;
  logic [2:0] cmd;
  logic signed [DataW-1:0] value;
  logic out_valid;
  logic out_ready;
  logic signed [DataW-1:0] data;
  logic [1:0] status;
  logic [CountW-1:0] count;
  logic is_empty;

  int fail_count, pending, level, checked, drops, empty_reads, peak;
  int items_sent = 0;
  bit tx_calm = 1'b0;

  ring_buffer_deque #(.DEPTH(Depth)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .data_o      (data),
    .status_o    (status),
    .count_o     (count),
    .is_empty_o  (is_empty)
  );

  deque_checker #(.DEPTH(Depth)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .cmd_i         (cmd),
    .value_i       (value),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .data_i        (data),
    .status_i      (status),
    .count_i       (count),
    .is_empty_i    (is_empty),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .level_o       (level),
    .checked_o     (checked),
    .drops_o       (drops),
    .empty_reads_o (empty_reads),
    .peak_o        (peak)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [2:0] pick_cmd(input mix_e mix);
    int roll;
    int push_f, push_b, pop_f, pop_b;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        push_f = 49; push_b = 98; pop_f = 99; pop_b = 99;
      end
      MIX_DRAIN: begin
        push_f = 5; push_b = 10; pop_f = 50; pop_b = 90;
      end
      default: begin
        push_f = 20; push_b = 40; pop_f = 55; pop_b = 70;
      end
    endcase
    if (roll < push_f) return CMD_PUSH_FRONT;
    if (roll < push_b) return CMD_PUSH_BACK;
    if (roll < pop_f) return CMD_POP_FRONT;
    if (roll < pop_b) return CMD_POP_BACK;
    roll = $urandom_range(9);
    if (roll < 4) return CMD_PEEK_FRONT;
    if (roll < 8) return CMD_PEEK_BACK;
    if (roll < 9) return CMD_STATUS;
    return CmdUnused;
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(31))
      0: return {1'b1, {(DataW-1){1'b0}}};
      1: return {1'b0, {(DataW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // offer one word and hold it until the deque takes it
  task automatic send_word(input logic [2:0] op, input logic [DataW-1:0] word);
    int gap;
    if ($urandom_range(39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    value    <= word;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  initial begin : receiver
    int stall_left;
    int rx_cycles;
    bit calm;
    stall_left = 0;
    rx_cycles  = 0;
    calm       = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if ($urandom_range(99) == 0) calm = !calm;
      if (rx_cycles == HoldStart) begin
        // long hold-off while the sender keeps offering, so the input side backs up
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    in_valid <= 1'b0;
    cmd      <= CMD_STATUS;
    value    <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty deque: every read and query
    send_word(CMD_STATUS, '0);
    send_word(CMD_POP_FRONT, '0);
    send_word(CMD_POP_BACK, '0);
    send_word(CMD_PEEK_FRONT, '0);
    send_word(CMD_PEEK_BACK, '0);
    send_word(CmdUnused, '1);
    // extreme words at both ends, then read them back out
    send_word(CMD_PUSH_BACK, {1'b0, {(DataW-1){1'b1}}});
    send_word(CMD_PUSH_FRONT, {1'b1, {(DataW-1){1'b0}}});
    send_word(CMD_PUSH_BACK, '0);
    send_word(CMD_PUSH_FRONT, '1);
    send_word(CMD_PEEK_FRONT, '0);
    send_word(CMD_PEEK_BACK, '0);
    send_word(CMD_POP_FRONT, '0);
    send_word(CMD_POP_BACK, '0);
    send_word(CMD_POP_FRONT, '0);
    send_word(CMD_POP_BACK, '0);
    send_word(CMD_PEEK_BACK, '0);
    send_word(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_word(CMD_PUSH_BACK, 32'h5555_5555);
    send_word(CMD_STATUS, '1);
    send_word(CmdUnused, '0);
    send_word(CMD_POP_BACK, '0);
    send_word(CMD_POP_FRONT, '0);
    send_word(CMD_STATUS, '0);

    // random: near empty, fill to the top, push while full, then drain a bit
    repeat (20) send_word(pick_cmd(MIX_EVEN), pick_value());
    while (level < Depth) send_word(pick_cmd(MIX_FILL), pick_value());
    repeat (20) send_word(pick_cmd(MIX_FILL), pick_value());
    while (level > Depth - 32) send_word(pick_cmd(MIX_DRAIN), pick_value());
    repeat (20) send_word(pick_cmd(MIX_EVEN), pick_value());
    in_valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d commands and checked %0d results, peak fill %0d of %0d",
             items_sent, checked, peak, Depth);
    $display("%0d pushes dropped while full, %0d pops or peeks on empty, one %0d-cycle hold-off",
             drops, empty_reads, HoldCycles);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still expected", CycleLimit, pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
